/* hw/rtl/lssi_pkg.sv */
`timescale 1ns / 1ps

package lssi_pkg;

	// Field widths of the stream payloads
	localparam int POS_W   = 10;
	localparam int REQ_W   = 8;
	localparam int IDX_W   = 3;
	localparam int LVL_W   = 7;
	localparam int RAD_W   = 9;
	localparam int START_W = 10;
	localparam int END_W   = 11;

	// Packed bus widths, padded to whole bytes
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 16;

	// Register port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 1;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_SPOT_RADIUS = 1'd0;

	localparam logic [RAD_W-1:0] RADIUS_RESET = 9'd80;
	localparam logic [LVL_W-1:0] LEVEL_MAX    = 7'd100;

endpackage

/* hw/rtl/led_strip_spot_intensity_unit.sv */
`timescale 1ns / 1ps

// Spot intensity distributor for a strip of LED_COUNT LEDs.
// Slave stream: one transaction per spot request (position, brightness).
// Master stream: LED_COUNT transactions per request, LED 0 first, tlast on
// the final LED. Each carries the LED index and its brightness percent.
// The APB port holds one register, the spot radius (byte address 0).
// A taken request is registered into the sequencer, and each LED then
// passes the pipeline stages below to the output; while the receiver does
// not stall, the block issues one result per cycle. The next request is
// taken in the cycle the last LED of the current one leaves the
// sequencer, so requests run back to back with no gap on the output.
// Datapath: a sequencer walks the LEDs of the held spot, then three stages:
// window compare and overlap, overlap times level, divide by LED_SPAN via
// a reciprocal multiply.
// Reset clears the sequencer and pipeline valids; the radius returns to 80.
// When the receiver stalls, the whole pipeline holds; the sequencer then
// keeps its spot and no new request is taken until its LEDs drain.
module led_strip_spot_intensity_unit #(
	parameter int LED_COUNT  = 5,
	parameter int TOTAL_SPAN = 800,
	parameter int LED_SPAN   = 160
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// [9:0] spot_position, [17:10] requested_level
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [lssi_pkg::S_DATA_W-1:0]        s_axis_tdata,

	// [2:0] led_index, [9:3] led_level; last_led on tlast
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [lssi_pkg::M_DATA_W-1:0]        m_axis_tdata,
	output logic                                 m_axis_tlast,

	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lssi_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [lssi_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [lssi_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);

	localparam int WIN_W   = 13;
	localparam int OV_W    = 10;
	localparam int NUM_W   = 17;
	localparam int SHIFT   = 27;
	localparam int RECIP_W = 27;
	localparam int PROD_W  = NUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**SHIFT + LED_SPAN - 1) / LED_SPAN);
	localparam logic [lssi_pkg::IDX_W-1:0] LAST_IDX = lssi_pkg::IDX_W'(LED_COUNT - 1);
	localparam logic [WIN_W-1:0] SPAN_W = WIN_W'(LED_SPAN);

	// ---------------- register port ----------------
	logic [lssi_pkg::RAD_W-1:0] radius_q;
	lssi_pkg::reg_idx_t         cfg_idx;
	logic                       cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[lssi_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= lssi_pkg::RADIUS_RESET;
		end else if (cfg_wr && cfg_idx == lssi_pkg::REG_SPOT_RADIUS) begin
			radius_q <= pwdata[lssi_pkg::RAD_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (cfg_idx == lssi_pkg::REG_SPOT_RADIUS) begin
			prdata = lssi_pkg::APB_DATA_W'(radius_q);
		end
	end

	// ---------------- request decode: clamp and lit interval ----------------
	logic [lssi_pkg::POS_W-1:0]   in_pos;
	logic [lssi_pkg::REQ_W-1:0]   in_lvl;
	logic [lssi_pkg::POS_W-1:0]   upper;
	logic [lssi_pkg::POS_W-1:0]   pos_c;
	logic [lssi_pkg::POS_W-1:0]   rad_ext;
	logic [lssi_pkg::START_W-1:0] start_d;
	logic [lssi_pkg::END_W-1:0]   end_d;
	logic [lssi_pkg::LVL_W-1:0]   lvl_d;

	assign in_pos  = s_axis_tdata[lssi_pkg::POS_W-1:0];
	assign in_lvl  = s_axis_tdata[lssi_pkg::POS_W +: lssi_pkg::REQ_W];
	assign rad_ext = lssi_pkg::POS_W'(radius_q);

	always_comb begin
		// upper bound saturates at zero when the radius exceeds the span
		upper = (lssi_pkg::POS_W'(TOTAL_SPAN) >= rad_ext)
			? lssi_pkg::POS_W'(TOTAL_SPAN) - rad_ext : '0;
		if (in_pos < rad_ext) begin
			pos_c = rad_ext;
		end else if (in_pos > upper) begin
			pos_c = upper;
		end else begin
			pos_c = in_pos;
		end
		start_d = (pos_c >= rad_ext) ? pos_c - rad_ext : '0;
		end_d   = lssi_pkg::END_W'(pos_c) + lssi_pkg::END_W'(radius_q);
		lvl_d   = (in_lvl > lssi_pkg::REQ_W'(lssi_pkg::LEVEL_MAX))
			? lssi_pkg::LEVEL_MAX : in_lvl[lssi_pkg::LVL_W-1:0];
	end

	// ---------------- LED sequencer ----------------
	logic [lssi_pkg::START_W-1:0] lit_start_q;
	logic [lssi_pkg::END_W-1:0]   lit_end_q;
	logic [lssi_pkg::LVL_W-1:0]   held_level_q;
	logic [lssi_pkg::IDX_W-1:0]   led_cnt_q;
	logic                         active_q;
	logic                         vld_s1, vld_s2, vld_s3;
	logic                         adv;
	logic                         emit;
	logic                         cnt_last;
	logic                         take;

	assign adv      = !vld_s3 || m_axis_tready;
	assign emit     = active_q && adv;
	assign cnt_last = (led_cnt_q == LAST_IDX);
	assign s_axis_tready = !active_q || (adv && cnt_last);
	assign take     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			led_cnt_q <= '0;
		end else begin
			if (emit) begin
				led_cnt_q <= cnt_last ? '0 : led_cnt_q + 1'b1;
			end
			if (take) begin
				active_q <= 1'b1;
			end else if (emit && cnt_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lit_start_q  <= start_d;
			lit_end_q    <= end_d;
			held_level_q <= lvl_d;
		end
	end

	// ---------------- stage 1: window compare and one-sided overlap ----------------
	logic [WIN_W-1:0] w_lo, w_hi, ls_ext, le_ext, ov_full;
	logic             no_touch, enclosed;

	always_comb begin
		w_lo     = WIN_W'(led_cnt_q) * SPAN_W;
		w_hi     = w_lo + SPAN_W;
		ls_ext   = WIN_W'(lit_start_q);
		le_ext   = WIN_W'(lit_end_q);
		no_touch = (ls_ext >= w_hi) || (le_ext <= w_lo);
		enclosed = (ls_ext < w_lo) && (le_ext > w_hi);
		if (no_touch) begin
			ov_full = '0;
		end else if (ls_ext >= w_lo) begin
			ov_full = w_hi - ls_ext;
		end else begin
			ov_full = le_ext - w_lo;
		end
	end

	logic [OV_W-1:0]            ov_s1;
	logic [lssi_pkg::LVL_W-1:0] lvl_s1, lvl_s2, lvl_s3;
	logic [lssi_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic                       full_s1, full_s2;
	logic                       last_s1, last_s2, last_s3;
	logic [NUM_W-1:0]           num_s2;
	logic [PROD_W-1:0]          prod;
	logic [NUM_W-1:0]           quot;

	// valid chain, held as a whole while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= emit;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// outside the enclosed case overlap never exceeds LED_SPAN, so it fits the 10-bit field
	always_ff @(posedge clk) begin
		if (adv) begin
			ov_s1   <= ov_full[OV_W-1:0];
			full_s1 <= enclosed;
			lvl_s1  <= held_level_q;
			idx_s1  <= led_cnt_q;
			last_s1 <= cnt_last;
		end
	end

	// ---------------- stage 2: rounded-up numerator ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2  <= NUM_W'(ov_s1) * NUM_W'(lvl_s1) + NUM_W'(LED_SPAN - 1);
			full_s2 <= full_s1;
			lvl_s2  <= lvl_s1;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
		end
	end

	// ---------------- stage 3: divide by LED_SPAN ----------------
	// numerator < 2^17 and reciprocal error < 2^10 keep the floor exact
	assign prod = PROD_W'(num_s2) * PROD_W'(RECIP);
	assign quot = prod[PROD_W-1:SHIFT];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (full_s2) begin
				lvl_s3 <= lvl_s2;
			end else if (quot > NUM_W'(lssi_pkg::LEVEL_MAX)) begin
				lvl_s3 <= lssi_pkg::LEVEL_MAX;
			end else begin
				lvl_s3 <= quot[lssi_pkg::LVL_W-1:0];
			end
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
		end
	end

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tlast  = last_s3;
	assign m_axis_tdata  = lssi_pkg::M_DATA_W'({lvl_s3, idx_s3});

endmodule

/* hw/rtl/lssi_checker.sv */
`timescale 1ns / 1ps

module lssi_checker #(
	parameter int LED_COUNT = 5
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [lssi_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tlast
);

	localparam logic [lssi_pkg::IDX_W-1:0] LAST_IDX = lssi_pkg::IDX_W'(LED_COUNT - 1);

	logic [lssi_pkg::IDX_W-1:0] out_idx;
	logic [lssi_pkg::LVL_W-1:0] out_lvl;
	logic [lssi_pkg::IDX_W-1:0] exp_idx_q;

	assign out_idx = m_axis_tdata[lssi_pkg::IDX_W-1:0];
	assign out_lvl = m_axis_tdata[lssi_pkg::IDX_W +: lssi_pkg::LVL_W];

	// next LED index expected on the result stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			exp_idx_q <= m_axis_tlast ? '0 : out_idx + 1'b1;
		end
	end

	// results walk the LEDs in order, starting again after each last
	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_idx == exp_idx_q)
		else $error("led index out of sequence");

	// tlast marks exactly the final LED
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (out_idx == LAST_IDX)))
		else $error("tlast does not match final led");

	// brightness never above full scale
	a_lvl_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_lvl <= lssi_pkg::LEVEL_MAX)
		else $error("led level above maximum");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind led_strip_spot_intensity_unit lssi_checker #(.LED_COUNT(LED_COUNT)) u_lssi_checker (.*);

/* dv/led_strip_spot_intensity_unit_test.sv */
`timescale 1ns / 1ps

module led_strip_spot_intensity_unit_test;

	import lssi_pkg::*;

	localparam int LED_COUNT  = 5;
	localparam int TOTAL_SPAN = 800;
	localparam int LED_SPAN   = 160;

	localparam int PHASE_ITEMS  = 65;
	localparam int DRAIN_CYCLES = 12;

	// register map: index 0 is the radius, index 1 is not mapped
	localparam logic [APB_ADDR_W-1:0] RADIUS_ADDR   = APB_ADDR_W'(REG_SPOT_RADIUS) << 2;
	localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

	typedef logic [LVL_W-1:0] level_set_t [LED_COUNT];

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [LVL_W-1:0] level;
		logic             last;
	} led_result_t;

	typedef struct {
		logic [RAD_W-1:0] radius;
		logic [POS_W-1:0] pos;
		logic [REQ_W-1:0] req;
		bit               typed;
		level_set_t       levels;
	} spot_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	led_result_t      expected_leds [$];
	logic [RAD_W-1:0] radius_q = RADIUS_RESET;
	int               send_idle = 0;
	int               recv_stall = 0;
	int               fail_count = 0;

	// directed requests; typed rows carry their LED levels, the rest use the predictor
	spot_row_t directed_rows [22] = '{
		'{9'd80,  10'd0,    8'd0,   1'b1, '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0}},
		'{9'd80,  10'd0,    8'd100, 1'b1, '{7'd100, 7'd0, 7'd0, 7'd0, 7'd0}},
		'{9'd80,  10'd1023, 8'd255, 1'b1, '{7'd0, 7'd0, 7'd0, 7'd0, 7'd100}},
		'{9'd80,  10'd400,  8'd101, 1'b1, '{7'd0, 7'd0, 7'd100, 7'd0, 7'd0}},
		'{9'd80,  10'd350,  8'd50,  1'b0, '{default: '0}},
		'{9'd80,  10'd79,   8'd77,  1'b0, '{default: '0}},
		'{9'd80,  10'd721,  8'd1,   1'b0, '{default: '0}},
		'{9'd80,  10'd512,  8'd128, 1'b0, '{default: '0}},
		'{9'd200, 10'd400,  8'd100, 1'b0, '{default: '0}},
		'{9'd200, 10'd0,    8'd99,  1'b0, '{default: '0}},
		'{9'd200, 10'd1000, 8'd3,   1'b0, '{default: '0}},
		'{9'd0,   10'd0,    8'd100, 1'b1, '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0}},
		'{9'd0,   10'd800,  8'd100, 1'b1, '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0}},
		'{9'd0,   10'd161,  8'd100, 1'b0, '{default: '0}},
		'{9'd511, 10'd300,  8'd100, 1'b0, '{default: '0}},
		'{9'd511, 10'd700,  8'd55,  1'b0, '{default: '0}},
		'{9'd400, 10'd400,  8'd100, 1'b1, '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100}},
		'{9'd401, 10'd0,    8'd200, 1'b0, '{default: '0}},
		'{9'd1,   10'd1023, 8'd100, 1'b0, '{default: '0}},
		'{9'd1,   10'd0,    8'd1,   1'b0, '{default: '0}},
		'{9'd160, 10'd480,  8'd100, 1'b0, '{default: '0}},
		'{9'd80,  10'd555,  8'd255, 1'b0, '{default: '0}}
	};

	int send_idle_pct  [4] = '{0, 56, 0, 33};
	int recv_stall_pct [4] = '{0, 0, 56, 33};

	led_strip_spot_intensity_unit #(
		.LED_COUNT  (LED_COUNT),
		.TOTAL_SPAN (TOTAL_SPAN),
		.LED_SPAN   (LED_SPAN)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Brightness of every LED for one spot request under the given radius
	function automatic level_set_t spot_levels(input logic [POS_W-1:0] pos_in,
	                                           input logic [REQ_W-1:0] req,
	                                           input logic [RAD_W-1:0] radius);
		int unsigned pos, r, upper, lo, hi, held, w_lo, w_hi, ov, v;
		int i;
		level_set_t lv;
		pos   = pos_in;
		r     = radius;
		upper = (TOTAL_SPAN >= r) ? TOTAL_SPAN - r : 0;
		if (pos < r)
			pos = r;
		else if (pos > upper)
			pos = upper;
		lo   = (pos >= r) ? ((pos - r) & 'h3FF) : 0;
		hi   = (pos + r) & 'h7FF;
		held = (req > LEVEL_MAX) ? LEVEL_MAX : req;
		for (i = 0; i < LED_COUNT; i++) begin
			w_lo = i * LED_SPAN;
			w_hi = (i + 1) * LED_SPAN;
			if (lo >= w_hi || hi <= w_lo) begin
				v = 0;
			end else if (lo < w_lo && hi > w_hi) begin
				v = held;
			end else begin
				// one-sided overlap, rounded up
				ov = (lo >= w_lo) ? w_hi - lo : hi - w_lo;
				v  = (ov * held + LED_SPAN - 1) / LED_SPAN;
				if (v > LEVEL_MAX)
					v = LEVEL_MAX;
			end
			lv[i] = LVL_W'(v);
		end
		return lv;
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endfunction

	// Receiver backpressure
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall);

	// Result checker: each LED transaction against the oldest expectation
	always @(posedge clk) begin
		led_result_t got;
		led_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W+LVL_W-1:IDX_W], m_axis_tlast};
			if (expected_leds.size() == 0) begin
				note_failure($sformatf("unexpected result idx=%0d level=%0d last=%0d",
					got.idx, got.level, got.last));
			end else begin
				want = expected_leds.pop_front();
				if (got.idx !== want.idx || got.level !== want.level
				    || got.last !== want.last)
					note_failure($sformatf("idx %0d/%0d level %0d/%0d last %0d/%0d (exp/act)",
						want.idx, got.idx, want.level, got.level, want.last, got.last));
			end
		end
	end

	// Offer one spot request and queue its LED levels once taken
	task automatic send_spot(input logic [POS_W-1:0] pos, input logic [REQ_W-1:0] req,
	                         input bit typed, input level_set_t typed_levels);
		level_set_t lv;
		int i;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(S_DATA_W-POS_W-REQ_W){1'b0}}, req, pos};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		lv = typed ? typed_levels : spot_levels(pos, req, radius_q);
		for (i = 0; i < LED_COUNT; i++)
			expected_leds.push_back('{IDX_W'(i), lv[i], (i == LED_COUNT - 1)});
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_leds.size() != 0)
			@(posedge clk);
	endtask

	task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
	                         input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == RADIUS_ADDR)
			radius_q = data[RAD_W-1:0];
		@(posedge clk);
	endtask

	// Read the radius back and compare with the tracked value
	task automatic radius_readback();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= RADIUS_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== APB_DATA_W'(radius_q))
			note_failure($sformatf("radius readback exp %0d act %0d", radius_q, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_radius(input logic [RAD_W-1:0] radius);
		logic [APB_DATA_W-1:0] word;
		// upper bits are don't-care for the register
		word = {$urandom()} & ~(APB_DATA_W'(1) << RAD_W) + 1;
		word = {word[APB_DATA_W-1:RAD_W], radius};
		reg_write(RADIUS_ADDR, word);
		radius_readback();
	endtask

	// Stimulus sequence
	initial begin
		int row, ph, n;
		logic [POS_W-1:0] pos;
		logic [REQ_W-1:0] req;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		radius_readback();

		// directed requests, radius changed only once the strip is idle
		for (row = 0; row < $size(directed_rows); row++) begin
			if (directed_rows[row].radius != radius_q) begin
				if (row != 0)
					wait_results_drained();
				set_radius(directed_rows[row].radius);
			end
			send_spot(directed_rows[row].pos, directed_rows[row].req,
				directed_rows[row].typed, directed_rows[row].levels);
		end

		// write to an unmapped index must leave the radius alone
		wait_results_drained();
		reg_write(UNMAPPED_ADDR, $urandom());
		radius_readback();

		// random phases with different idle patterns and radii
		for (ph = 0; ph < 4; ph++) begin
			wait_results_drained();
			send_idle  = send_idle_pct[ph];
			recv_stall = recv_stall_pct[ph];
			case (ph)
				0: set_radius(RAD_W'($urandom_range(1, 399)));
				1: set_radius(9'd511);
				2: set_radius(9'd0);
				default: set_radius(RAD_W'($urandom_range(401, 510)));
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// halfway through phase 1 the sender holds off until the strip has fully drained
				if (ph == 1 && n == PHASE_ITEMS / 2)
					wait_results_drained();
				pos = POS_W'($urandom_range(0, 1023));
				req = REQ_W'($urandom_range(1) ? $urandom_range(0, 100)
				                               : $urandom_range(0, 255));
				send_spot(pos, req, 1'b0, '{default: '0});
			end
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_leds.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_leds.size()));
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
